FILE: rtl/scc_pkg.sv
// Shared types and constants for the skin color pixel classifier.
// Depends on nothing; used by every module in rtl/.
`timescale 1ns / 1ps

package scc_pkg;

    // Width of one color component and of a hue limit register
    localparam int unsigned COMP_W = 8;
    localparam int unsigned HUE_W  = 13;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_HUE_LOW  = 1'b0,
        REG_HUE_HIGH = 1'b1
    } t_cfg_reg;

    // Reset values of the hue limits, sixteenths of a degree
    localparam logic [HUE_W-1:0] HUE_LOW_RESET  = 13'd565;
    localparam logic [HUE_W-1:0] HUE_HIGH_RESET = 13'd5195;

    // Input item: one RGB pixel
    typedef struct packed {
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
    } t_pix_in;

    // Result item: skin flag and masked pixel
    typedef struct packed {
        logic              is_skin;
        logic [COMP_W-1:0] out_red;
        logic [COMP_W-1:0] out_green;
        logic [COMP_W-1:0] out_blue;
    } t_pix_out;

endpackage

FILE: rtl/scc_rgb_rule.sv
// RGB skin rule: daylight branch or flash branch.
// Depends on scc_pkg (pixel type).
`timescale 1ns / 1ps

module scc_rgb_rule (
    input  scc_pkg::t_pix_in i_pix,
    output logic             o_pass
);

    logic [7:0] r, g, b;
    logic [7:0] mx, mn, d, drg;
    logic       day, flash;

    // Find spread of the components
    always_comb begin
        r   = i_pix.red;
        g   = i_pix.green;
        b   = i_pix.blue;
        mx  = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        mn  = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        d   = mx - mn;
        drg = (r > g) ? (r - g) : (g - r);
    end

    // Evaluate both lighting branches
    always_comb begin
        day   = (r > 8'd95) && (g > 8'd40) && (b > 8'd20) && (d > 8'd15) &&
                (drg > 8'd15) && (r > g) && (r > b);
        flash = (r > 8'd220) && (g > 8'd210) && (b > 8'd170) && (drg <= 8'd15) &&
                (r > b) && (g > b);
        o_pass = day || flash;
    end

endmodule

FILE: rtl/scc_chroma_rule.sv
// Chroma skin rule: BT.601 Cr/Cb in fixed point, five linear bounds on Cr vs Cb.
// Depends on scc_pkg (pixel type).
`timescale 1ns / 1ps

module scc_chroma_rule (
    input  scc_pkg::t_pix_in i_pix,
    output logic             o_pass
);

    logic [22:0]        ysum;
    logic [7:0]         y;
    logic signed [24:0] rd, bd, cr_arg, cb_arg;
    logic [7:0]         cr, cb;
    logic signed [25:0] cr_s, cb_s, c;
    logic               e3, e4, e5, e6, e7;

    // Drop negatives, scale down, saturate at full scale
    function automatic logic [7:0] sat_u8(input logic signed [24:0] v);
        logic [10:0] s;
        s = v[24:14];
        if (v[24]) begin
            sat_u8 = 8'd0;
        end else if (s > 11'd255) begin
            sat_u8 = 8'hFF;
        end else begin
            sat_u8 = s[7:0];
        end
    endfunction

    // Luma, rounded to 8 bits
    always_comb begin
        ysum = 23'd1868 * {15'b0, i_pix.blue} + 23'd9617 * {15'b0, i_pix.green} +
               23'd4899 * {15'b0, i_pix.red} + 23'd8192;
        y    = ysum[21:14];
    end

    // Color differences, offset and rounded
    always_comb begin
        rd     = $signed({17'b0, i_pix.red})  - $signed({17'b0, y});
        bd     = $signed({17'b0, i_pix.blue}) - $signed({17'b0, y});
        cr_arg = rd * 25'sd11682 + 25'sd2105344;
        cb_arg = bd * 25'sd9241 + 25'sd2105344;
        cr     = sat_u8(cr_arg);
        cb     = sat_u8(cb_arg);
    end

    // Bounds scaled by 10000, compared exactly
    always_comb begin
        cr_s   = $signed({18'b0, cr});
        cb_s   = $signed({18'b0, cb});
        c      = cr_s * 26'sd10000;
        e3     = c <= cb_s * 26'sd15862 + 26'sd200000;
        e4     = c >= cb_s * 26'sd3448 + 26'sd762069;
        e5     = c >= cb_s * (-26'sd45652) + 26'sd2345652;
        e6     = c <= cb_s * (-26'sd11500) + 26'sd3017500;
        e7     = c <= cb_s * (-26'sd22857) + 26'sd4328500;
        o_pass = e3 && e4 && e5 && e6 && e7;
    end

endmodule

FILE: rtl/scc_hue_rule.sv
// Hue window rule by cross-multiplication against the two hue limits.
// Depends on scc_pkg (pixel type, limit width).
`timescale 1ns / 1ps

module scc_hue_rule (
    input  scc_pkg::t_pix_in          i_pix,
    input  logic [scc_pkg::HUE_W-1:0] i_hue_low,
    input  logic [scc_pkg::HUE_W-1:0] i_hue_high,
    output logic                      o_pass
);

    logic [7:0]         r, g, b, mx, mn, d;
    logic signed [22:0] r_s, g_s, b_s, d_s, n, t;
    logic signed [22:0] low_d, high_d;

    // Range of the components
    always_comb begin
        r   = i_pix.red;
        g   = i_pix.green;
        b   = i_pix.blue;
        mx  = (r > g) ? ((r > b) ? r : b) : ((g > b) ? g : b);
        mn  = (r < g) ? ((r < b) ? r : b) : ((g < b) ? g : b);
        d   = mx - mn;
        r_s = $signed({15'b0, r});
        g_s = $signed({15'b0, g});
        b_s = $signed({15'b0, b});
        d_s = $signed({15'b0, d});
    end

    // Hue numerator over d, by dominant component
    always_comb begin
        t = 23'sd960 * (g_s - b_s);
        if ((r >= g) && (r >= b)) begin
            n = t[22] ? (t + 23'sd5760 * d_s) : t;
        end else if (g >= b) begin
            n = 23'sd1920 * d_s + 23'sd960 * (b_s - r_s);
        end else begin
            n = 23'sd3840 * d_s + 23'sd960 * (r_s - g_s);
        end
    end

    // Compare against both limits scaled by d; grey takes hue zero
    always_comb begin
        low_d  = $signed({10'b0, i_hue_low}) * d_s;
        high_d = $signed({10'b0, i_hue_high}) * d_s;
        if (d == 8'd0) begin
            o_pass = (i_hue_low != '0);
        end else begin
            o_pass = (n < low_d) || (n > high_d);
        end
    end

endmodule

FILE: rtl/skin_color_pixel_classifier.sv
// Top level of the skin color pixel classifier: input register, three rule
// checks, result register, hue limit registers. Depends on scc_pkg and the scc_* rules.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                 payload
//  pixel in  in         i_valid / o_stall         i_pix  (scc_pkg::t_pix_in)
//  result    out        o_valid / i_stall         o_pix  (scc_pkg::t_pix_out)
//  config    in         i_cfg_we (no wait)        i_cfg_index, i_cfg_data
//
//  One item per cycle sustained while i_stall stays low; an accepted item waits in
//  the input register, then moves to the result register, where o_valid shows it.
//  The rule logic sits between the input register and the result register.
//  Reset (synchronous, active low) empties both stages and loads the hue limits
//  with 565 and 5195. o_stall rises only when both stages hold items and the
//  result is stalled, so a waiting result does not block a new item otherwise.

module skin_color_pixel_classifier (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  scc_pkg::t_pix_in              i_pix,
    output logic                          o_valid,
    input  logic                          i_stall,
    output scc_pkg::t_pix_out             o_pix,
    input  logic                          i_cfg_we,
    input  scc_pkg::t_cfg_reg             i_cfg_index,
    input  logic [scc_pkg::HUE_W-1:0]     i_cfg_data
);

    logic                      r_s1_valid;
    scc_pkg::t_pix_in          r_s1_pix;
    logic                      r_out_valid;
    scc_pkg::t_pix_out         r_out_pix;
    scc_pkg::t_pix_out         n_out_pix;
    logic [scc_pkg::HUE_W-1:0] r_hue_low, r_hue_high;
    logic                      adv_out;
    logic                      rgb_ok, chroma_ok, hue_ok, skin;

    // Hold hue limits; take writes by index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_low  <= scc_pkg::HUE_LOW_RESET;
            r_hue_high <= scc_pkg::HUE_HIGH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                scc_pkg::REG_HUE_LOW:  r_hue_low  <= i_cfg_data;
                scc_pkg::REG_HUE_HIGH: r_hue_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance when the result register is empty or being taken
    assign adv_out = !r_out_valid || !i_stall;
    assign o_stall = r_s1_valid && !adv_out;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_stall) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_s1_pix <= i_pix;
        end
    end

    // Rule checks
    scc_rgb_rule u_rgb (
        .i_pix  (r_s1_pix),
        .o_pass (rgb_ok)
    );

    scc_chroma_rule u_chroma (
        .i_pix  (r_s1_pix),
        .o_pass (chroma_ok)
    );

    scc_hue_rule u_hue (
        .i_pix      (r_s1_pix),
        .i_hue_low  (r_hue_low),
        .i_hue_high (r_hue_high),
        .o_pass     (hue_ok)
    );

    // Pass skin pixels, blank the rest
    always_comb begin
        skin                = rgb_ok && chroma_ok && hue_ok;
        n_out_pix.is_skin   = skin;
        n_out_pix.out_red   = skin ? r_s1_pix.red   : '0;
        n_out_pix.out_green = skin ? r_s1_pix.green : '0;
        n_out_pix.out_blue  = skin ? r_s1_pix.blue  : '0;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_out && r_s1_valid) begin
            r_out_pix <= n_out_pix;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pix   = r_out_pix;

`ifndef SYNTHESIS
    // A stall upstream only happens with both stages occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid))
        else $error("input stalled with a free stage");

    // An item in the input register reaches the output when it is free
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && adv_out) |=> o_valid)
        else $error("item lost between stages");

    // Non-skin results are black
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_pix.is_skin) |->
        (o_pix.out_red == '0 && o_pix.out_green == '0 && o_pix.out_blue == '0))
        else $error("non-skin pixel not blanked");

    // Skin results carry the pixel that was in the input register
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && adv_out) |=>
        (!o_pix.is_skin || (o_pix.out_red == $past(r_s1_pix.red) &&
                            o_pix.out_green == $past(r_s1_pix.green) &&
                            o_pix.out_blue == $past(r_s1_pix.blue))))
        else $error("skin pixel altered");
`endif

endmodule
